// ----- sv/krge_pkg.sv -----
// Package: types and constants of the keypad repeat and gesture engine.
package krge_pkg;
  localparam int KeyCount    = 11;
  localparam int ActionCount = 8;
  localparam int ChordCount  = 4;
  localparam int MapField    = 11;
  localparam int CfgWidth    = 44;
  localparam int CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] CFG_REPEAT_DELAY  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_REPEAT_PERIOD = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_TAP_MAX       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_DBL_WINDOW    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_HOLD_THRESH   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_MAP_LOW       = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_MAP_HIGH      = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_CHORD_MAP     = 3'd7;

  typedef struct packed {
    logic        action;
    logic [10:0] raw_key_bits;
  } in_word_t;

  typedef struct packed {
    logic [10:0] keys_down;
    logic [21:0] key_edges;
    logic [10:0] keys_repeated;
    logic [7:0]  actions_down;
    logic [15:0] action_edges;
    logic [7:0]  actions_rpt;
    logic [7:0]  actions_tap;
    logic [7:0]  actions_dtap;
    logic [7:0]  actions_hold_began;
    logic [7:0]  actions_long_held;
    logic [7:0]  actions_hold_released;
    logic [3:0]  chords_fired;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEY_DIV, ST_KEY_NEXT, ST_ACT, ST_DONE
  } state_t;
endpackage

// ----- sv/krge_if.sv -----
// Interface: valid/ready channel carrying one word.
interface krge_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/keypad_repeat_gesture_engine_top.sv -----
// Top level: keypad auto-repeat and tap/hold gesture engine.
// A frame word, once accepted, is processed in steps: each key in turn, plus a pass through one
// shared bit-serial remainder unit for each key held past its press whose count is at or above
// the repeat delay while the repeat period is nonzero, then the mapping of keys to actions, each
// action in turn and the assembly of the result. A drain word goes straight to result assembly.
// The result waits in an output register; the next word is taken the cycle after it left.
module keypad_repeat_gesture_engine_top (
  input  logic clk,
  input  logic rst,
  krge_if.sink   in_ch,
  krge_if.source out_ch,
  input  logic                              cfg_we,
  input  logic [krge_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [krge_pkg::CfgWidth-1:0]     cfg_data
);
  import krge_pkg::*;

  logic [7:0] rpt_delay, rpt_period, tap_max, dbl_window, hold_thresh;
  logic [43:0] map_low, map_high;
  logic [31:0] chord_map;

  logic [10:0] prev_keys, drained;
  logic [7:0]  key_cnt [KeyCount];
  logic [7:0]  prev_act, long_hold;
  logic [7:0]  act_cnt [ActionCount];
  logic [7:0]  dtc [ActionCount];

  state_t state, state_next;
  logic [3:0] idx;
  logic [3:0] bitn;
  logic [7:0] rem;
  logic [7:0] dividend;
  logic [10:0] held, pressed, released, repeated;
  logic [7:0] act, spress, srel, tapped, dbl, began, hrel;
  out_word_t res;
  logic out_valid;

  function automatic logic [7:0] to_act(input logic [10:0] k, input logic [43:0] lo,
                                        input logic [43:0] hi);
    logic [7:0] r;
    r = '0;
    for (int a = 0; a < 4; a++) begin
      r[a]   = |(k & lo[a*MapField +: MapField]);
      r[a+4] = |(k & hi[a*MapField +: MapField]);
    end
    return r;
  endfunction

  assign in_ch.ready  = (state == ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  logic [7:0] kc_inc;
  logic [8:0] rem_sh, rem_sub;
  logic [2:0] ai;
  assign ai = idx[2:0];
  assign kc_inc = (key_cnt[idx] == 8'hFF) ? 8'hFF : key_cnt[idx] + 8'd1;
  assign rem_sh = {rem, dividend[7]};
  assign rem_sub = rem_sh - {1'b0, rpt_period};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_ch.valid && in_ch.ready)
                     state_next = in_ch.data.action ? ST_DONE : ST_KEY_NEXT;
      ST_KEY_NEXT: if (idx == 4'(KeyCount)) state_next = ST_ACT;
                   else if (held[idx] && !pressed[idx] && rpt_period != 0 &&
                            kc_inc >= rpt_delay) state_next = ST_KEY_DIV;
      ST_KEY_DIV:  if (bitn == 4'd7) state_next = ST_KEY_NEXT;
      ST_ACT:      if (idx == 4'(ActionCount - 1)) state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_delay <= 8'd20; rpt_period <= 8'd5; tap_max <= 8'd12;
      dbl_window <= 8'd15; hold_thresh <= 8'd30;
      map_low <= '0; map_high <= '0; chord_map <= '0;
      prev_keys <= '0; drained <= '0; prev_act <= '0; long_hold <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < KeyCount; i++) key_cnt[i] <= '0;
      for (int i = 0; i < ActionCount; i++) begin
        act_cnt[i] <= '0; dtc[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPEAT_DELAY:  rpt_delay     <= cfg_data[7:0];
          CFG_REPEAT_PERIOD: rpt_period    <= cfg_data[7:0];
          CFG_TAP_MAX:       tap_max       <= cfg_data[7:0];
          CFG_DBL_WINDOW:    dbl_window    <= cfg_data[7:0];
          CFG_HOLD_THRESH:   hold_thresh   <= cfg_data[7:0];
          CFG_MAP_LOW:       map_low       <= cfg_data;
          CFG_MAP_HIGH:      map_high      <= cfg_data;
          CFG_CHORD_MAP:     chord_map     <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          idx <= '0;
          res <= '0;
          if (in_ch.data.action) begin
            drained <= drained | prev_keys;
            prev_keys <= '0; prev_act <= '0; long_hold <= '0;
            for (int i = 0; i < ActionCount; i++) begin
              act_cnt[i] <= '0; dtc[i] <= '0;
            end
          end else begin
            drained  <= drained & in_ch.data.raw_key_bits;
            held     <= in_ch.data.raw_key_bits & ~drained;
            pressed  <= in_ch.data.raw_key_bits & ~drained & ~prev_keys;
            released <= prev_keys & ~(in_ch.data.raw_key_bits & ~drained);
            repeated <= '0;
          end
          tapped <= '0; dbl <= '0; began <= '0; hrel <= '0;
        end
        ST_KEY_NEXT: if (idx != 4'(KeyCount)) begin
          if (!held[idx]) key_cnt[idx] <= '0;
          else if (pressed[idx]) begin
            key_cnt[idx] <= '0; repeated[idx] <= 1'b1;
          end else begin
            key_cnt[idx] <= kc_inc;
            dividend <= kc_inc - rpt_delay;
            rem <= '0; bitn <= '0;
          end
          if (state_next != ST_KEY_DIV) idx <= idx + 4'd1;
        end else begin
          idx <= '0;
          act <= to_act(held, map_low, map_high);
          spress <= to_act(held, map_low, map_high) & ~prev_act;
          srel <= prev_act & ~to_act(held, map_low, map_high);
          prev_keys <= held;
        end
        ST_KEY_DIV: begin
          rem <= rem_sub[8] ? rem_sh[7:0] : rem_sub[7:0];
          dividend <= {dividend[6:0], 1'b0};
          bitn <= bitn + 4'd1;
          if (bitn == 4'd7) begin
            if ((rem_sub[8] ? rem_sh : rem_sub) == 9'd0) repeated[idx] <= 1'b1;
            idx <= idx + 4'd1;
          end
        end
        ST_ACT: begin
          logic tap, lh;
          logic [7:0] cnt, d;
          cnt = act_cnt[ai];
          d = dtc[ai];
          lh = long_hold[ai];
          tap = 1'b0;
          if (spress[ai]) cnt = 8'd1;
          else if (act[ai] && cnt != 8'hFF) cnt = cnt + 8'd1;
          if (act[ai] && cnt >= hold_thresh && !lh) begin
            lh = 1'b1; began[ai] <= 1'b1; d = '0;
          end
          if (srel[ai]) begin
            if (lh) hrel[ai] <= 1'b1;
            else if (cnt != 8'd0 && cnt <= tap_max) begin
              tapped[ai] <= 1'b1; tap = 1'b1;
            end else d = '0;
            cnt = '0; lh = 1'b0;
          end
          if (tap) begin
            if (d != 8'd0) begin dbl[ai] <= 1'b1; d = '0; end
            else d = dbl_window;
          end else if (d != 8'd0) d = d - 8'd1;
          act_cnt[ai] <= cnt;
          dtc[ai] <= d;
          long_hold[ai] <= lh;
          idx <= idx + 4'd1;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          if (idx != 4'd0) begin
            res.keys_down <= held;
            res.key_edges <= {released, pressed};
            res.keys_repeated <= repeated;
            res.actions_down <= act;
            res.action_edges <= {to_act(released, map_low, map_high),
                                 to_act(pressed, map_low, map_high)};
            res.actions_rpt <= to_act(repeated, map_low, map_high);
            res.actions_tap <= tapped;
            res.actions_dtap <= dbl;
            res.actions_hold_began <= began;
            res.actions_long_held <= long_hold;
            res.actions_hold_released <= hrel;
            for (int c = 0; c < ChordCount; c++)
              res.chords_fired[c] <= (chord_map[8*c +: 8] != 8'd0) &&
                ((chord_map[8*c +: 8] & (chord_map[8*c +: 8] - 8'd1)) != 8'd0) &&
                ((spress & chord_map[8*c +: 8]) == chord_map[8*c +: 8]);
            prev_act <= act;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/krge_checker.sv -----
// Checker: port-level properties of the engine, bound to the top level.
module krge_props (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input krge_pkg::out_word_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_sub: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.actions_tap & out_data.actions_hold_released) == 8'd0)
    else $error("tap and hold release together");
endmodule

bind keypad_repeat_gesture_engine_top krge_props u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
